// File: hdl/qeti_pkg.sv
// Shared types, constants and helpers for the quartic escape-time iterator.
package qeti_pkg;

    localparam int DATA_W          = 32;
    localparam int CNT_W           = 16;
    localparam int CFG_IDX_W       = 3;
    localparam int FRAC_BITS_DEF   = 24;
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int ESC_RADIUS_SQ   = 1000;
    localparam int NORM_W          = 68;
    localparam int WIDE_W          = 66;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_A_RE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_A_IM   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_B_RE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_B_IM   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LAM_RE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LAM_IM = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_EPS    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_MAXIT  = 3'd7;

    // datapath operations
    localparam logic [2:0] OP_NONE = 3'd0;
    localparam logic [2:0] OP_NORM = 3'd1;
    localparam logic [2:0] OP_NEG  = 3'd2;
    localparam logic [2:0] OP_MUL  = 3'd3;
    localparam logic [2:0] OP_ADD  = 3'd4;

    // Horner coefficient select
    localparam logic [1:0] CSEL_B   = 2'd0;
    localparam logic [1:0] CSEL_LAM = 2'd1;
    localparam logic [1:0] CSEL_EPS = 2'd2;

    typedef struct packed {
        logic       load;
        logic [2:0] op;
        logic [1:0] csel;
    } dp_cmd_t;

    typedef struct packed {
        logic escape;
    } dp_status_t;

    typedef struct packed {
        logic             done;
        logic             bounded;
        logic [CNT_W-1:0] count;
    } result_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] a_re;
        logic signed [DATA_W-1:0] a_im;
        logic signed [DATA_W-1:0] b_re;
        logic signed [DATA_W-1:0] b_im;
        logic signed [DATA_W-1:0] lam_re;
        logic signed [DATA_W-1:0] lam_im;
        logic signed [DATA_W-1:0] eps;
    } coefs_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] x);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = WIDE_W'(64'sh7FFF_FFFF);
        lo = -WIDE_W'(64'sh8000_0000);
        if (x > hi)
            return DATA_W'(hi);
        else if (x < lo)
            return DATA_W'(lo);
        else
            return x[DATA_W-1:0];
    endfunction

    function automatic logic sat_hit(input logic signed [WIDE_W-1:0] x);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = WIDE_W'(64'sh7FFF_FFFF);
        lo = -WIDE_W'(64'sh8000_0000);
        return (x > hi) || (x < lo);
    endfunction

endpackage

// File: hdl/qeti_if.sv
// Valid/ready channel interfaces for start points and escape results.
interface qeti_in_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [qeti_pkg::DATA_W-1:0]     start_re;
    logic signed [qeti_pkg::DATA_W-1:0]     start_im;

    modport source (output valid, output start_re, output start_im, input ready);
    modport sink   (input valid, input start_re, input start_im, output ready);
endinterface

interface qeti_out_if;
    logic                          valid;
    logic                          ready;
    logic [qeti_pkg::CNT_W-1:0]    escape_count;
    logic                          stayed_bounded;

    modport source (output valid, output escape_count, output stayed_bounded, input ready);
    modport sink   (input valid, input escape_count, input stayed_bounded, output ready);
endinterface

// File: hdl/quartic_escape_time_iterator_unit.sv
// Quartic escape-time iterator: takes a complex start point p (signed Q8.24 by
// default) and repeatedly applies p <- (((a - p) p + b) p + lambda) p + epsilon,
// counting steps until |p|^2 >= 1000, a component saturates, or max_iter steps
// (capped at 2^COUNT_WIDTH - 1) are done. One result beat per input beat:
// escape_count, plus stayed_bounded = 1 when the limit was hit. Points are
// handled one at a time. Each iteration runs norm square, test, negate, then
// three multiply/add pairs on the shared complex multiplier; max_iter resets
// to 50. The finished result sits in an output register, so the next start
// point is accepted while a result beat is still waiting on the sink.
// Configuration is a write-only port (index = register order a_re, a_im, b_re,
// b_im, lambda_re, lambda_im, epsilon, max_iter); write only while idle.
module quartic_escape_time_iterator_unit #(
    parameter int FRAC_BITS   = qeti_pkg::FRAC_BITS_DEF,
    parameter int COUNT_WIDTH = qeti_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [qeti_pkg::CFG_IDX_W-1:0]       cfg_idx,
    input  logic [qeti_pkg::DATA_W-1:0]          cfg_data,
    qeti_in_if.sink                              in_ch,
    qeti_out_if.source                           out_ch
);
    qeti_pkg::coefs_t           coefs_reg;
    logic [qeti_pkg::CNT_W-1:0] max_iter_reg;

    qeti_pkg::dp_cmd_t          cmd;
    qeti_pkg::dp_status_t       status;
    qeti_pkg::result_t          res;
    logic                       idle;
    logic                       in_fire;
    logic                       out_free;

    logic                       out_valid_reg;
    logic [qeti_pkg::CNT_W-1:0] out_count_reg;
    logic                       out_bounded_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coefs_reg.a_re   <= qeti_pkg::DATA_W'(64'sd1 <<< FRAC_BITS);
            coefs_reg.a_im   <= '0;
            coefs_reg.b_re   <= '0;
            coefs_reg.b_im   <= '0;
            coefs_reg.lam_re <= qeti_pkg::DATA_W'(64'sd1 <<< FRAC_BITS);
            coefs_reg.lam_im <= '0;
            coefs_reg.eps    <= '0;
            max_iter_reg     <= qeti_pkg::CNT_W'(50);
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                qeti_pkg::CFG_A_RE:   coefs_reg.a_re   <= cfg_data;
                qeti_pkg::CFG_A_IM:   coefs_reg.a_im   <= cfg_data;
                qeti_pkg::CFG_B_RE:   coefs_reg.b_re   <= cfg_data;
                qeti_pkg::CFG_B_IM:   coefs_reg.b_im   <= cfg_data;
                qeti_pkg::CFG_LAM_RE: coefs_reg.lam_re <= cfg_data;
                qeti_pkg::CFG_LAM_IM: coefs_reg.lam_im <= cfg_data;
                qeti_pkg::CFG_EPS:    coefs_reg.eps    <= cfg_data;
                default:              max_iter_reg     <= cfg_data[qeti_pkg::CNT_W-1:0];
            endcase
        end
    end

    assign in_ch.ready = idle;
    assign in_fire     = in_ch.valid && idle;

    // result slot frees up when empty or being drained this cycle
    assign out_free = !out_valid_reg || out_ch.ready;

    qeti_ctrl #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .out_free (out_free),
        .max_iter (max_iter_reg),
        .status   (status),
        .idle     (idle),
        .cmd      (cmd),
        .res      (res)
    );

    qeti_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .coefs    (coefs_reg),
        .start_re (in_ch.start_re),
        .start_im (in_ch.start_im),
        .status   (status)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res.done)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res.done)
        begin
            out_count_reg   <= res.count;
            out_bounded_reg <= res.bounded;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.escape_count   = out_count_reg;
    assign out_ch.stayed_bounded = out_bounded_reg;

endmodule

// File: hdl/qeti_datapath.sv
// Complex multiply-add datapath: four shared multipliers, saturation, norm test.
module qeti_datapath #(
    parameter int FRAC_BITS = qeti_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  qeti_pkg::dp_cmd_t                  cmd,
    input  qeti_pkg::coefs_t                   coefs,
    input  logic signed [qeti_pkg::DATA_W-1:0] start_re,
    input  logic signed [qeti_pkg::DATA_W-1:0] start_im,
    output qeti_pkg::dp_status_t               status
);
    localparam int W  = qeti_pkg::DATA_W;
    localparam int WW = qeti_pkg::WIDE_W;
    localparam int NW = qeti_pkg::NORM_W;
    localparam logic [NW-1:0] THRESH = NW'(qeti_pkg::ESC_RADIUS_SQ) << (2 * FRAC_BITS);

    logic signed [W-1:0]   p_re_reg, p_im_reg, q_re_reg, q_im_reg;
    logic signed [W-1:0]   p_re_next, p_im_next, q_re_next, q_im_next;
    logic signed [2*W-1:0] rr_reg, ii_reg, ri_reg, ir_reg;
    logic                  ovf_reg, ovf_next;

    logic signed [W-1:0]   x_re, x_im;
    logic signed [W-1:0]   c_re, c_im;
    logic signed [WW-1:0]  neg_re, neg_im, sum_re, sum_im;
    logic signed [WW-1:0]  rr_s, ii_s, ri_s, ir_s;
    logic [NW-1:0]         norm;

    // norm step squares p; Horner steps multiply q by p
    assign x_re = (cmd.op == qeti_pkg::OP_NORM) ? p_re_reg : q_re_reg;
    assign x_im = (cmd.op == qeti_pkg::OP_NORM) ? p_im_reg : q_im_reg;

    always_ff @(posedge clk)
    begin
        rr_reg <= x_re * p_re_reg;
        ii_reg <= x_im * p_im_reg;
        ri_reg <= x_re * p_im_reg;
        ir_reg <= x_im * p_re_reg;
    end

    // arithmetic shift of the exact product floors it
    assign rr_s = $signed({{(WW-2*W){rr_reg[2*W-1]}}, rr_reg}) >>> FRAC_BITS;
    assign ii_s = $signed({{(WW-2*W){ii_reg[2*W-1]}}, ii_reg}) >>> FRAC_BITS;
    assign ri_s = $signed({{(WW-2*W){ri_reg[2*W-1]}}, ri_reg}) >>> FRAC_BITS;
    assign ir_s = $signed({{(WW-2*W){ir_reg[2*W-1]}}, ir_reg}) >>> FRAC_BITS;

    always_comb
    begin
        unique case (cmd.csel)
            qeti_pkg::CSEL_B:
            begin
                c_re = coefs.b_re;
                c_im = coefs.b_im;
            end
            qeti_pkg::CSEL_LAM:
            begin
                c_re = coefs.lam_re;
                c_im = coefs.lam_im;
            end
            default:
            begin
                c_re = coefs.eps;
                c_im = '0;
            end
        endcase
    end

    assign neg_re = WW'(coefs.a_re) - WW'(p_re_reg);
    assign neg_im = WW'(coefs.a_im) - WW'(p_im_reg);
    assign sum_re = rr_s - ii_s + WW'(c_re);
    assign sum_im = ri_s + ir_s + WW'(c_im);

    always_comb
    begin
        p_re_next = p_re_reg;
        p_im_next = p_im_reg;
        q_re_next = q_re_reg;
        q_im_next = q_im_reg;
        ovf_next  = ovf_reg;
        if (cmd.load)
        begin
            p_re_next = start_re;
            p_im_next = start_im;
            ovf_next  = 1'b0;
        end
        else if (cmd.op == qeti_pkg::OP_NEG)
        begin
            q_re_next = qeti_pkg::sat32(neg_re);
            q_im_next = qeti_pkg::sat32(neg_im);
            ovf_next  = ovf_reg | qeti_pkg::sat_hit(neg_re) | qeti_pkg::sat_hit(neg_im);
        end
        else if (cmd.op == qeti_pkg::OP_ADD)
        begin
            q_re_next = qeti_pkg::sat32(sum_re);
            q_im_next = qeti_pkg::sat32(sum_im);
            ovf_next  = ovf_reg | qeti_pkg::sat_hit(sum_re) | qeti_pkg::sat_hit(sum_im);
            if (cmd.csel == qeti_pkg::CSEL_EPS)
            begin
                p_re_next = q_re_next;
                p_im_next = q_im_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        p_re_reg <= p_re_next;
        p_im_reg <= p_im_next;
        q_re_reg <= q_re_next;
        q_im_reg <= q_im_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovf_reg <= 1'b0;
        else
            ovf_reg <= ovf_next;
    end

    // squares are never negative
    assign norm = NW'($unsigned(rr_reg)) + NW'($unsigned(ii_reg));
    assign status.escape = ovf_reg || (norm >= THRESH);

endmodule

// File: hdl/qeti_ctrl.sv
// Iteration sequencer: steps the datapath through norm, negate and three Horner stages.
module qeti_ctrl #(
    parameter int COUNT_WIDTH = qeti_pkg::COUNT_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_fire,
    input  logic                              out_free,
    input  logic [qeti_pkg::CNT_W-1:0]        max_iter,
    input  qeti_pkg::dp_status_t              status,
    output logic                              idle,
    output qeti_pkg::dp_cmd_t                 cmd,
    output qeti_pkg::result_t                 res
);
    localparam int CW = qeti_pkg::CNT_W;
    localparam logic [CW-1:0] CAP =
        (COUNT_WIDTH >= CW) ? {CW{1'b1}} : CW'((64'd1 << COUNT_WIDTH) - 64'd1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_NORM  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_NEG   = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_ADD   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next, lim_reg, lim_next;
    logic [1:0]    csel_reg, csel_next;
    logic          bounded_reg, bounded_next;

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        lim_next     = lim_reg;
        csel_next    = csel_reg;
        bounded_next = bounded_reg;
        cmd.load     = 1'b0;
        cmd.op       = qeti_pkg::OP_NONE;
        cmd.csel     = csel_reg;
        idle         = 1'b0;
        res.done     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                idle = 1'b1;
                if (in_fire)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    lim_next   = (max_iter > CAP) ? CAP : max_iter;
                    state_next = S_NORM;
                end
            end
            S_NORM:
            begin
                cmd.op     = qeti_pkg::OP_NORM;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (cnt_reg == lim_reg)
                begin
                    bounded_next = 1'b1;
                    state_next   = S_DONE;
                end
                else if (status.escape)
                begin
                    bounded_next = 1'b0;
                    state_next   = S_DONE;
                end
                else
                    state_next = S_NEG;
            end
            S_NEG:
            begin
                cmd.op     = qeti_pkg::OP_NEG;
                csel_next  = qeti_pkg::CSEL_B;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.op     = qeti_pkg::OP_MUL;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                cmd.op = qeti_pkg::OP_ADD;
                if (csel_reg == qeti_pkg::CSEL_EPS)
                begin
                    cnt_next   = cnt_reg + CW'(1);
                    state_next = S_NORM;
                end
                else
                begin
                    csel_next  = csel_reg + 2'd1;
                    state_next = S_MUL;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    res.done   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    assign res.bounded = bounded_reg;
    assign res.count   = cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            lim_reg     <= '0;
            csel_reg    <= qeti_pkg::CSEL_B;
            bounded_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            lim_reg     <= lim_next;
            csel_reg    <= csel_next;
            bounded_reg <= bounded_next;
        end
    end

endmodule

// File: dv/quartic_escape_time_iterator_unit_tb.sv
// Testbench for the quartic escape-time iterator: directed and random start points with self-checking.
`timescale 1ns / 100ps

module quartic_escape_time_iterator_unit_tb;
    import qeti_pkg::*;

    localparam int  Q_ONE       = 1 << FRAC_BITS_DEF;
    localparam int  CYCLE_LIMIT = 3_000_000;
    localparam int  SETTLE      = 30;

    typedef struct {
        logic [CNT_W-1:0] count;
        logic             bounded;
    } escape_result_t;

    // Scoreboard: owns a copy of the coefficient set and predicts one escape
    // result per accepted start point; results are compared in order.
    class escape_scoreboard;
        longint           a_re, a_im, b_re, b_im, lam_re, lam_im, eps;
        logic [CNT_W-1:0] iter_limit;
        escape_result_t   pending_q[$];
        int               errors;

        function new();
            a_re = Q_ONE; a_im = 0; b_re = 0; b_im = 0;
            lam_re = Q_ONE; lam_im = 0; eps = 0;
            iter_limit = 50;
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
            longint v;
            v = longint'(signed'(data));
            case (idx)
                CFG_A_RE:   a_re = v;
                CFG_A_IM:   a_im = v;
                CFG_B_RE:   b_re = v;
                CFG_B_IM:   b_im = v;
                CFG_LAM_RE: lam_re = v;
                CFG_LAM_IM: lam_im = v;
                CFG_EPS:    eps = v;
                CFG_MAXIT:  iter_limit = data[CNT_W-1:0];
                default: ;
            endcase
        endfunction

        // clamp to 32-bit signed, flag sticks once set
        function longint clamp32(longint x, ref bit sat);
            if (x > 64'sd2147483647)
            begin
                sat = 1;
                return 64'sd2147483647;
            end
            if (x < -64'sd2147483648)
            begin
                sat = 1;
                return -64'sd2147483648;
            end
            return x;
        endfunction

        // fixed-point product, arithmetic shift = floor rounding
        function longint qmul(longint x, longint y);
            return (x * y) >>> FRAC_BITS_DEF;
        endfunction

        // q * p + c per component, saturated
        function void horner_stage(ref longint qr, ref longint qi, input longint pr,
                                   input longint pi, input longint cr, input longint ci,
                                   ref bit sat);
            longint r, m;
            r  = qmul(qr, pr) - qmul(qi, pi) + cr;
            m  = qmul(qr, pi) + qmul(qi, pr) + ci;
            qr = clamp32(r, sat);
            qi = clamp32(m, sat);
        endfunction

        function void note_start(logic [DATA_W-1:0] sre, logic [DATA_W-1:0] sim);
            longint         pr, pi, qr, qi;
            logic [63:0]    mag_sq;
            bit             sat;
            int unsigned    steps;
            escape_result_t res;
            pr = longint'(signed'(sre));
            pi = longint'(signed'(sim));
            sat = 0;
            steps = 0;
            while (steps < iter_limit)
            begin
                mag_sq = 64'(pr * pr) + 64'(pi * pi);
                if (sat || ((mag_sq >> FRAC_BITS_DEF) >= (64'd1000 << FRAC_BITS_DEF)))
                    break;
                qr = clamp32(a_re - pr, sat);
                qi = clamp32(a_im - pi, sat);
                horner_stage(qr, qi, pr, pi, b_re, b_im, sat);
                horner_stage(qr, qi, pr, pi, lam_re, lam_im, sat);
                horner_stage(qr, qi, pr, pi, eps, 0, sat);
                pr = qr;
                pi = qi;
                steps++;
            end
            res.count   = CNT_W'(steps);
            res.bounded = (steps >= iter_limit);
            pending_q.push_back(res);
        endfunction

        function void check_result(logic [CNT_W-1:0] cnt, logic bnd);
            escape_result_t exp_res;
            if (pending_q.size() == 0)
            begin
                $error("result beat with nothing expected: escape_count=%0d stayed_bounded=%0d",
                       cnt, bnd);
                errors++;
                return;
            end
            exp_res = pending_q.pop_front();
            if (cnt !== exp_res.count)
            begin
                $error("escape_count: expected %0d, actual %0d", exp_res.count, cnt);
                errors++;
            end
            if (bnd !== exp_res.bounded)
            begin
                $error("stayed_bounded: expected %0d, actual %0d", exp_res.bounded, bnd);
                errors++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [DATA_W-1:0]    cfg_data;

    qeti_in_if  in_ch();
    qeti_out_if out_ch();

    quartic_escape_time_iterator_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .in_ch    (in_ch.sink),
        .out_ch   (out_ch.source)
    );

    escape_scoreboard sb = new();

    int send_idle_pct;   // chance per slot that the sender holds valid low
    int sink_stall_pct;  // chance per cycle that the receiver drops ready
    int hold_off_cycles; // long receiver stall, counted down in the sink process
    int start_beats;
    int cycles;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Watchdog: any hang ends the run as a failure.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("quartic_escape_time_iterator_unit_tb: done, errors");
            $finish;
        end
    end

    // Monitors sample at the rising edge, before the block's updates land.
    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            sb.note_start(in_ch.start_re, in_ch.start_im);
            start_beats++;
        end
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_result(out_ch.escape_count, out_ch.stayed_bounded);
    end

    // Receiver: random stalls, plus an optional long hold-off.
    always @(negedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            hold_off_cycles--;
            out_ch.ready = 1'b0;
        end
        else
            out_ch.ready = ($urandom_range(99) >= sink_stall_pct);
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = data;
        sb.set_reg(idx, data);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic write_coefs(logic [DATA_W-1:0] are, logic [DATA_W-1:0] aim,
                               logic [DATA_W-1:0] bre, logic [DATA_W-1:0] bim,
                               logic [DATA_W-1:0] lre, logic [DATA_W-1:0] lim,
                               logic [DATA_W-1:0] e, logic [CNT_W-1:0] lim_iter);
        write_reg(CFG_A_RE, are);
        write_reg(CFG_A_IM, aim);
        write_reg(CFG_B_RE, bre);
        write_reg(CFG_B_IM, bim);
        write_reg(CFG_LAM_RE, lre);
        write_reg(CFG_LAM_IM, lim);
        write_reg(CFG_EPS, e);
        write_reg(CFG_MAXIT, DATA_W'(lim_iter));
    endtask

    // One start beat; called at a falling edge, returns at one.
    task automatic send_point(logic [DATA_W-1:0] sre, logic [DATA_W-1:0] sim);
        int seen;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        seen = start_beats;
        in_ch.valid    = 1'b1;
        in_ch.start_re = sre;
        in_ch.start_im = sim;
        do
            @(negedge clk);
        while (start_beats == seen);
    endtask

    // Sender goes quiet until every expected result is back.
    task automatic drain();
        in_ch.valid = 1'b0;
        while (sb.pending_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // Signed value uniform in +/- 2^mag_bits.
    function automatic logic [DATA_W-1:0] rand_q(int mag_bits);
        longint span;
        span = longint'(1) << mag_bits;
        return DATA_W'(longint'($urandom_range(0, 32'(2 * span))) - span);
    endfunction

    // Mostly points near the interesting region, some full-range noise.
    function automatic logic [DATA_W-1:0] rand_coord();
        if ($urandom_range(9) == 0)
            return $urandom;
        return rand_q(FRAC_BITS_DEF + 1);
    endfunction

    // Coordinate with magnitude >= 32.0, so a point holding it starts outside the escape radius.
    function automatic logic [DATA_W-1:0] far_coord();
        logic [DATA_W-1:0] v;
        v = $urandom;
        v[30:29] = v[31] ? 2'b00 : 2'b11;
        v[30]    = ~v[31];
        return v;
    endfunction

    task automatic random_phase(int n, int idle_pct, int stall_pct);
        send_idle_pct  = idle_pct;
        sink_stall_pct = stall_pct;
        write_coefs(rand_q(FRAC_BITS_DEF + 1), rand_q(FRAC_BITS_DEF + 1),
                    rand_q(FRAC_BITS_DEF), rand_q(FRAC_BITS_DEF),
                    rand_q(FRAC_BITS_DEF + 1), rand_q(FRAC_BITS_DEF),
                    rand_q(FRAC_BITS_DEF - 1), CNT_W'($urandom_range(1, 40)));
        repeat (n) send_point(rand_coord(), rand_coord());
        drain();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_idx        = '0;
        cfg_data       = '0;
        in_ch.valid    = 1'b0;
        in_ch.start_re = '0;
        in_ch.start_im = '0;
        out_ch.ready   = 1'b0;
        send_idle_pct  = 0;
        sink_stall_pct = 0;
        hold_off_cycles = 0;
        start_beats    = 0;
        cycles         = 0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset coefficients: origin stays put (bounded), field extremes,
        // a point just inside the radius whose first step saturates.
        send_point(32'h0000_0000, 32'h0000_0000);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(32'h8000_0000, 32'h8000_0000);
        send_point(32'h7FFF_FFFF, 32'h8000_0000);
        send_point(32'h8000_0000, 32'h0000_0000);
        send_point(32'h0000_0000, 32'h7FFF_FFFF);
        send_point(32'(Q_ONE), 32'h0000_0000);
        send_point(32'h0000_0000, 32'(Q_ONE));
        send_point(32'(31 * Q_ONE), 32'h0000_0000);
        send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_point(32'(Q_ONE / 2), 32'(-Q_ONE / 2));
        drain();

        // Limit of one: saturation on the only allowed step reads as bounded;
        // a point already outside gives count 0, not bounded.
        write_reg(CFG_MAXIT, 32'd1);
        send_point(32'(31 * Q_ONE), 32'h0000_0000);
        send_point(32'h0000_0000, 32'h0000_0000);
        send_point(32'(32 * Q_ONE), 32'h0000_0000);
        drain();

        // Extreme coefficients and the largest limit; epsilon at full scale
        // throws every orbit out within a step or two.
        write_coefs(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                    32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF);
        send_point(32'h0000_0000, 32'h0000_0000);
        send_point(32'h0000_0001, 32'hFFFF_FFFF);
        repeat (6) send_point(far_coord(), $urandom);
        drain();
        write_reg(CFG_EPS, 32'h8000_0000);
        send_point(32'h0000_0000, 32'h0000_0000);
        repeat (3) send_point($urandom, far_coord());
        drain();

        // Random phases: one per idling mode; the first also holds the
        // receiver off long enough to back the block up to its input.
        hold_off_cycles = 3000;
        random_phase(105, 0, 0);
        random_phase(105, 86, 0);
        random_phase(105, 0, 86);
        random_phase(105, 8, 8);

        if (sb.errors == 0)
            $display("quartic_escape_time_iterator_unit_tb: done, clean");
        else
            $display("quartic_escape_time_iterator_unit_tb: done, errors");
        $finish;
    end

endmodule

// File: sim.f
hdl/qeti_pkg.sv
hdl/qeti_if.sv
hdl/qeti_datapath.sv
hdl/qeti_ctrl.sv
hdl/quartic_escape_time_iterator_unit.sv
dv/quartic_escape_time_iterator_unit_tb.sv
